>>> sv/asft_pkg.sv
package asft_pkg;

    localparam int ANGLE_W = 16;
    localparam int POS_W   = 30;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SYS_ERR   = 3'd1,
        ST_IF_ERR    = 3'd2,
        ST_ANGLE_ERR = 3'd3,
        ST_CRC_ERR   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_SYS_MASK   = 2'd0,
        CFG_IF_MASK    = 2'd1,
        CFG_ANGLE_MASK = 2'd2,
        CFG_WRAP_THR   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] sys_mask;
        logic [15:0] if_mask;
        logic [15:0] angle_mask;
        logic [13:0] wrap_threshold;
    } t_cfg;

    // one classified frame on its way from front to back
    typedef struct packed {
        t_status              status;
        logic [ANGLE_W-1:0]   angle;
    } t_item;

endpackage

>>> sv/asft_front.sv
module asft_front #(
    parameter int COUNTS_PER_TURN = 8192
) (
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_command_word,
    input  logic [15:0]         i_angle_word,
    input  logic [15:0]         i_safety_word,
    input  asft_pkg::t_cfg      i_cfg,
    input  logic                i_full,
    output logic                o_push,
    output asft_pkg::t_item     o_item
);
    import asft_pkg::*;

    localparam logic [7:0] CRC_POLY = 8'h1d;
    localparam logic [7:0] CRC_INIT = 8'hff;
    localparam int         RAW_W    = 13;
    localparam int         PROD_W   = RAW_W + ANGLE_W;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [7:0]         crc;
    logic [RAW_W-1:0]   raw;
    logic [PROD_W-1:0]  prod;
    t_status            status;

    always_comb begin
        crc = crc8_update(CRC_INIT, i_command_word[15:8]);
        crc = crc8_update(crc, i_command_word[7:0]);
        crc = crc8_update(crc, i_angle_word[15:8]);
        crc = crc8_update(crc, i_angle_word[7:0]);

        // status bits are active low, checked in priority order
        if ((i_safety_word & i_cfg.sys_mask) == 16'd0) begin
            status = ST_SYS_ERR;
        end else if ((i_safety_word & i_cfg.if_mask) == 16'd0) begin
            status = ST_IF_ERR;
        end else if ((i_safety_word & i_cfg.angle_mask) == 16'd0) begin
            status = ST_ANGLE_ERR;
        end else if (i_safety_word[7:0] != ~crc) begin
            status = ST_CRC_ERR;
        end else begin
            status = ST_OK;
        end
    end

    // raw angle counts down; rescale from 13 bits to counts per turn
    assign raw  = i_angle_word[14:2];
    assign prod = PROD_W'(raw) * PROD_W'(COUNTS_PER_TURN);

    assign o_item.status = status;
    assign o_item.angle  = ANGLE_W'(COUNTS_PER_TURN) - prod[PROD_W-1:RAW_W];

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

>>> sv/asft_queue.sv
module asft_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  asft_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output asft_pkg::t_item o_item,
    input  logic            i_pop
);
    import asft_pkg::*;

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wp;
    logic [PTR_W-1:0]   n_rp;
    logic               do_pop;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    assign n_wp = (r_wp == PTR_W'(QDEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
    assign n_rp = (r_rp == PTR_W'(QDEPTH - 1)) ? '0 : r_rp + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= n_wp;
            end
            if (do_pop) begin
                r_rp <= n_rp;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> sv/asft_back.sv
module asft_back #(
    parameter int COUNTS_PER_TURN = 8192,
    parameter int TURN_BITS       = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  asft_pkg::t_item     i_q_item,
    output logic                o_pop,
    input  logic [13:0]         i_wrap_threshold,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [13:0]         o_angle_counts,
    output logic signed [15:0]  o_turn_count,
    output logic                o_moving_up,
    output logic signed [29:0]  o_position
);
    import asft_pkg::*;

    localparam int     DIFF_W = ANGLE_W + 2;
    localparam longint TMAX_L = (longint'(1) <<< (TURN_BITS - 1)) - 1;
    localparam longint TMIN_L = -(longint'(1) <<< (TURN_BITS - 1));
    localparam logic [TURN_BITS-1:0] T_MAX   = TURN_BITS'(TMAX_L);
    localparam logic [TURN_BITS-1:0] T_MIN   = TURN_BITS'(TMIN_L);
    // turns * counts, modulo the position width, at the two wrap points
    localparam logic [POS_W-1:0]     TC_MAX  = POS_W'(TMAX_L * longint'(COUNTS_PER_TURN));
    localparam logic [POS_W-1:0]     TC_MIN  = POS_W'(TMIN_L * longint'(COUNTS_PER_TURN));
    localparam logic [POS_W-1:0]     TC_STEP = POS_W'(COUNTS_PER_TURN);

    logic                   r_out_valid;
    t_status                r_status;
    logic [13:0]            r_prev;
    logic [TURN_BITS-1:0]   r_turns;
    logic [POS_W-1:0]       r_tc;
    logic                   r_seeded;
    logic                   r_up;
    logic [POS_W-1:0]       r_pos;

    logic [13:0]            n_prev;
    logic [TURN_BITS-1:0]   n_turns;
    logic [POS_W-1:0]       n_tc;
    logic                   n_seeded;
    logic                   n_up;
    logic [POS_W-1:0]       n_pos;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic                     wrap;
    logic                     pos_jump;

    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    assign diff     = signed'(DIFF_W'(i_q_item.angle)) - signed'(DIFF_W'(r_prev));
    assign mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign wrap     = mag > DIFF_W'(i_wrap_threshold);
    assign pos_jump = !diff[DIFF_W-1] && (diff != '0);

    always_comb begin
        n_prev   = r_prev;
        n_turns  = r_turns;
        n_tc     = r_tc;
        n_seeded = r_seeded;
        n_up     = r_up;
        if (i_q_item.status == ST_OK) begin
            n_prev = i_q_item.angle[13:0];
            if (!r_seeded) begin
                n_seeded = 1'b1;
                n_up     = 1'b0;
            end else begin
                n_up = pos_jump;
                if (wrap && pos_jump) begin
                    n_turns = r_turns - TURN_BITS'(1);
                    n_tc    = (r_turns == T_MIN) ? TC_MAX : r_tc - TC_STEP;
                end else if (wrap) begin
                    n_turns = r_turns + TURN_BITS'(1);
                    n_tc    = (r_turns == T_MAX) ? TC_MIN : r_tc + TC_STEP;
                end
            end
        end
        n_pos = n_tc + POS_W'(n_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_turns     <= '0;
            r_tc        <= '0;
            r_seeded    <= 1'b0;
            r_up        <= 1'b0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_prev      <= n_prev;
                r_turns     <= n_turns;
                r_tc        <= n_tc;
                r_seeded    <= n_seeded;
                r_up        <= n_up;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_q_item.status;
            r_pos    <= n_pos;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_angle_counts = r_prev;
    assign o_turn_count   = signed'(16'(r_turns));
    assign o_moving_up    = r_up;
    assign o_position     = signed'(r_pos);

endmodule

>>> sv/angle_sensor_frame_tracker.sv
// angle sensor frame tracker
// input channel: i_valid / o_stall with the command, angle and safety words of
// one sensor frame; a transfer happens on a clock edge with i_valid high and
// o_stall low. output channel: o_valid / i_stall with status, angle, turn
// count, direction and multi-turn position; one result per input frame.
// the front checks the status bits and the crc-8 of the frame in the cycle of
// the transfer and writes the classified frame into a two-entry queue; the
// back pops it, updates the turn tracking state and loads the output register.
// o_valid rises once the frame has passed the queue and the output register;
// one frame per cycle is sustained while the receiver does not stall.
// when the receiver stalls, the output holds, the queue fills and o_stall
// rises once both entries are taken.
// reset (synchronous, active low) empties the queue and output, clears the
// tracking state and loads the default masks and wrap threshold.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx; the user must
// write only while the block is idle, and the block itself does not enforce it.
module angle_sensor_frame_tracker #(
    parameter int COUNTS_PER_TURN = 8192,
    parameter int TURN_BITS       = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [15:0]         i_command_word,
    input  logic [15:0]         i_angle_word,
    input  logic [15:0]         i_safety_word,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [13:0]         o_angle_counts,
    output logic signed [15:0]  o_turn_count,
    output logic                o_moving_up,
    output logic signed [29:0]  o_position
);
    import asft_pkg::*;

    t_cfg   r_cfg;
    logic   push;
    t_item  push_item;
    logic   q_full;
    logic   q_valid;
    t_item  q_item;
    logic   pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sys_mask       <= 16'h4000;
            r_cfg.if_mask        <= 16'h2000;
            r_cfg.angle_mask     <= 16'h1000;
            r_cfg.wrap_threshold <= 14'd6553;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SYS_MASK:   r_cfg.sys_mask       <= i_cfg_data;
                CFG_IF_MASK:    r_cfg.if_mask        <= i_cfg_data;
                CFG_ANGLE_MASK: r_cfg.angle_mask     <= i_cfg_data;
                CFG_WRAP_THR:   r_cfg.wrap_threshold <= i_cfg_data[13:0];
                default:        r_cfg.sys_mask       <= r_cfg.sys_mask;
            endcase
        end
    end

    asft_front #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN)
    ) u_front (
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command_word (i_command_word),
        .i_angle_word   (i_angle_word),
        .i_safety_word  (i_safety_word),
        .i_cfg          (r_cfg),
        .i_full         (q_full),
        .o_push         (push),
        .o_item         (push_item)
    );

    asft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    asft_back #(
        .COUNTS_PER_TURN(COUNTS_PER_TURN),
        .TURN_BITS      (TURN_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_pop            (pop),
        .i_wrap_threshold (r_cfg.wrap_threshold),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_angle_counts   (o_angle_counts),
        .o_turn_count     (o_turn_count),
        .o_moving_up      (o_moving_up),
        .o_position       (o_position)
    );

endmodule
